// File: hdl/terminal_line_editor_top_assert.svh
// Assertion macros for the line editor.
`ifndef TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
// same-cycle implication
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/tle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tle_pkg;
    localparam logic [3:0] EV_NONE = 4'd0;
    localparam logic [3:0] EV_HIST_UP = 4'd1;
    localparam logic [3:0] EV_HIST_DOWN = 4'd2;
    localparam logic [3:0] EV_CANCEL = 4'd3;
    localparam logic [3:0] EV_EOF = 4'd4;
    localparam logic [3:0] EV_TAB = 4'd5;
    localparam logic [3:0] EV_ENTER = 4'd6;
    localparam logic [3:0] EV_CLEAR = 4'd7;
    localparam logic [3:0] EV_HELP = 4'd8;

    localparam logic [1:0] FN_KEY = 2'd0;
    localparam logic [1:0] FN_CLEAR = 2'd1;
    localparam logic [1:0] FN_READ = 2'd2;

    localparam logic [7:0] K_HOME = 8'd1;
    localparam logic [7:0] K_LEFT = 8'd2;
    localparam logic [7:0] K_CANCEL = 8'd3;
    localparam logic [7:0] K_DEL = 8'd4;
    localparam logic [7:0] K_END = 8'd5;
    localparam logic [7:0] K_RIGHT = 8'd6;
    localparam logic [7:0] K_BS = 8'd8;
    localparam logic [7:0] K_TAB = 8'd9;
    localparam logic [7:0] K_LF = 8'd10;
    localparam logic [7:0] K_KILL_EOL = 8'd11;
    localparam logic [7:0] K_FF = 8'd12;
    localparam logic [7:0] K_CR = 8'd13;
    localparam logic [7:0] K_KILL_LINE = 8'd21;
    localparam logic [7:0] K_KILL_WORD = 8'd23;
    localparam logic [7:0] K_ESC = 8'd27;
    localparam logic [7:0] K_SPACE = 8'd32;
    localparam logic [7:0] K_HELP = 8'd63;
    localparam logic [7:0] K_RUBOUT = 8'd127;
    localparam logic [7:0] K_LBRACKET = 8'd91;
    localparam logic [7:0] K_SEMI = 8'd59;
    localparam logic [7:0] K_TILDE = 8'd126;
    localparam logic [7:0] K_ZERO = 8'd48;
    localparam logic [7:0] K_NINE = 8'd57;
    localparam logic [7:0] K_A = 8'd65;
    localparam logic [7:0] K_B = 8'd66;
    localparam logic [7:0] K_C = 8'd67;
    localparam logic [7:0] K_D = 8'd68;
    localparam logic [7:0] K_F = 8'd70;
    localparam logic [7:0] K_H = 8'd72;
    localparam logic [7:0] K_WB = 8'd98;
    localparam logic [7:0] K_WF = 8'd102;

    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_ESC = 3'd1;
    localparam logic [2:0] PH_CSI = 3'd2;
    localparam logic [2:0] PH_P1 = 3'd3;
    localparam logic [2:0] PH_SEMI = 3'd4;
    localparam logic [2:0] PH_P2 = 3'd5;

    typedef enum logic [2:0] {CUR_HOLD, CUR_ZERO, CUR_INC, CUR_DEC, CUR_END} cur_op_t;
    typedef enum logic [2:0] {LEN_HOLD, LEN_ZERO, LEN_INC, LEN_CUR, LEN_DST} len_op_t;
    typedef enum logic [2:0] {SRC_HOLD, SRC_LEN, SRC_CUR, SRC_CUR_P1, SRC_INC, SRC_DEC} src_op_t;
    typedef enum logic [1:0] {DST_HOLD, DST_CUR, DST_INC} dst_op_t;
    typedef enum logic [2:0] {RD_CUR_M1, RD_CUR, RD_SRC, RD_SRC_M1, RD_IDX} rd_sel_t;
    typedef enum logic [1:0] {WR_DST, WR_SRC, WR_CUR_KEY} wr_sel_t;

    typedef struct packed {
        cur_op_t cur_op;
        len_op_t len_op;
        src_op_t src_op;
        dst_op_t dst_op;
        logic rd_en;
        rd_sel_t rd_sel;
        logic wr_en;
        wr_sel_t wr_sel;
        logic [7:0] key;
        logic [6:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic cur_zero;
        logic cur_lt_len;
        logic src_lt_len;
        logic src_eq_cur;
        logic rd_space;
        logic len_full;
        logic len_zero;
        logic idx_lt_len;
        logic [7:0] rdata;
        logic [6:0] cur7;
        logic [6:0] len7;
    } dp_status_t;
endpackage
`default_nettype wire

// File: hdl/tle_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tle_datapath
    import tle_pkg::*;
#(
    parameter int LINE_SIZE = 128
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire dp_cmd_t cmd,
    output dp_status_t st
);
    localparam int AW = $clog2(LINE_SIZE);
    localparam int CW = (AW > 7) ? AW : 7;

    logic [7:0] line_mem [LINE_SIZE];
    logic [7:0] rdata_reg;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [AW-1:0] raddr, waddr;
    logic [7:0] wdata;

    always_comb
    begin
        cursor_next = cursor_reg;
        case (cmd.cur_op)
            CUR_ZERO: cursor_next = '0;
            CUR_INC: cursor_next = cursor_reg + 1'b1;
            CUR_DEC: cursor_next = cursor_reg - 1'b1;
            CUR_END: cursor_next = len_reg;
            default: cursor_next = cursor_reg;
        endcase
        len_next = len_reg;
        case (cmd.len_op)
            LEN_ZERO: len_next = '0;
            LEN_INC: len_next = len_reg + 1'b1;
            LEN_CUR: len_next = cursor_reg;
            LEN_DST: len_next = dst_reg;
            default: len_next = len_reg;
        endcase
        src_next = src_reg;
        case (cmd.src_op)
            SRC_LEN: src_next = len_reg;
            SRC_CUR: src_next = cursor_reg;
            SRC_CUR_P1: src_next = cursor_reg + 1'b1;
            SRC_INC: src_next = src_reg + 1'b1;
            SRC_DEC: src_next = src_reg - 1'b1;
            default: src_next = src_reg;
        endcase
        dst_next = dst_reg;
        case (cmd.dst_op)
            DST_CUR: dst_next = cursor_reg;
            DST_INC: dst_next = dst_reg + 1'b1;
            default: dst_next = dst_reg;
        endcase
        case (cmd.rd_sel)
            RD_CUR_M1: raddr = cursor_reg - 1'b1;
            RD_CUR: raddr = cursor_reg;
            RD_SRC: raddr = src_reg;
            RD_SRC_M1: raddr = src_reg - 1'b1;
            RD_IDX: raddr = AW'(cmd.idx);
            default: raddr = cursor_reg;
        endcase
        case (cmd.wr_sel)
            WR_DST:
            begin
                waddr = dst_reg;
                wdata = rdata_reg;
            end
            WR_SRC:
            begin
                waddr = src_reg;
                wdata = rdata_reg;
            end
            WR_CUR_KEY:
            begin
                waddr = cursor_reg;
                wdata = cmd.key;
            end
            default:
            begin
                waddr = dst_reg;
                wdata = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            line_mem[waddr] <= wdata;
        if (cmd.rd_en)
            rdata_reg <= line_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            len_reg <= '0;
            src_reg <= '0;
            dst_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            len_reg <= len_next;
            src_reg <= src_next;
            dst_reg <= dst_next;
        end
    end

    always_comb
    begin
        st.cur_zero = (cursor_reg == '0);
        st.cur_lt_len = (cursor_reg < len_reg);
        st.src_lt_len = (src_reg < len_reg);
        st.src_eq_cur = (src_reg == cursor_reg);
        st.rd_space = (rdata_reg == K_SPACE);
        st.len_full = (len_reg == AW'(LINE_SIZE - 1));
        st.len_zero = (len_reg == '0);
        st.idx_lt_len = (CW'(cmd.idx) < CW'(len_reg));
        st.rdata = rdata_reg;
        st.cur7 = 7'(cursor_reg);
        st.len7 = 7'(len_reg);
    end
endmodule
`default_nettype wire

// File: hdl/tle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tle_ctrl
    import tle_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic [1:0] func,
    input wire logic [7:0] key_byte,
    input wire logic [6:0] read_index,
    output logic out_valid,
    input wire logic out_stall,
    output logic [3:0] event_res,
    output logic [6:0] cursor_out,
    output logic [6:0] length_out,
    output logic [7:0] read_char,
    output dp_cmd_t cmd,
    input wire dp_status_t st
);
    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_DECODE = 17'h00002,
        S_INS = 17'h00004,
        S_INS_WR = 17'h00008,
        S_DEL_CHK = 17'h00010,
        S_CP_RD = 17'h00020,
        S_CP_WR = 17'h00040,
        S_WB1_RD = 17'h00080,
        S_WB1_CK = 17'h00100,
        S_WB2_RD = 17'h00200,
        S_WB2_CK = 17'h00400,
        S_WF1_RD = 17'h00800,
        S_WF1_CK = 17'h01000,
        S_WF2_RD = 17'h02000,
        S_WF2_CK = 17'h04000,
        S_READ_WAIT = 17'h08000,
        S_FINISH = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] func_reg, func_next;
    logic [7:0] key_reg, key_next;
    logic [6:0] idx_reg, idx_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] p1_reg, p1_next;
    logic [7:0] p2_reg, p2_next;
    logic [3:0] ev_reg, ev_next;
    logic [7:0] rc_reg, rc_next;
    logic kill_reg, kill_next;
    logic out_valid_reg, out_valid_next;
    logic [3:0] out_ev_reg, out_ev_next;
    logic [6:0] out_cur_reg, out_cur_next;
    logic [6:0] out_len_reg, out_len_next;
    logic [7:0] out_rc_reg, out_rc_next;

    logic is_digit;
    logic [3:0] digit;
    logic [11:0] p1_mac, p2_mac;
    logic [7:0] p1_sat, p2_sat;

    assign is_digit = (key_reg >= K_ZERO) && (key_reg <= K_NINE);
    assign digit = 4'(key_reg - K_ZERO);
    assign p1_mac = ({4'b0, p1_reg} << 3) + ({4'b0, p1_reg} << 1) + 12'(digit);
    assign p2_mac = ({4'b0, p2_reg} << 3) + ({4'b0, p2_reg} << 1) + 12'(digit);
    assign p1_sat = (p1_mac > 12'd255) ? 8'd255 : p1_mac[7:0];
    assign p2_sat = (p2_mac > 12'd255) ? 8'd255 : p2_mac[7:0];

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        key_next = key_reg;
        idx_next = idx_reg;
        phase_next = phase_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        ev_next = ev_reg;
        rc_next = rc_reg;
        kill_next = kill_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_ev_next = out_ev_reg;
        out_cur_next = out_cur_reg;
        out_len_next = out_len_reg;
        out_rc_next = out_rc_reg;

        cmd.cur_op = CUR_HOLD;
        cmd.len_op = LEN_HOLD;
        cmd.src_op = SRC_HOLD;
        cmd.dst_op = DST_HOLD;
        cmd.rd_en = 1'b0;
        cmd.rd_sel = RD_CUR;
        cmd.wr_en = 1'b0;
        cmd.wr_sel = WR_DST;
        cmd.key = key_reg;
        cmd.idx = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    key_next = key_byte;
                    idx_next = read_index;
                    ev_next = EV_NONE;
                    rc_next = 8'd0;
                    kill_next = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (func_reg == FN_CLEAR)
                begin
                    cmd.cur_op = CUR_ZERO;
                    cmd.len_op = LEN_ZERO;
                end
                else if (func_reg == FN_READ)
                begin
                    if (st.idx_lt_len)
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_sel = RD_IDX;
                        state_next = S_READ_WAIT;
                    end
                end
                else if (func_reg == FN_KEY)
                begin
                    logic csi;
                    csi = 1'b0;
                    phase_next = PH_NONE;
                    case (phase_reg)
                        PH_ESC:
                        begin
                            if (key_reg == K_LBRACKET)
                            begin
                                phase_next = PH_CSI;
                                p1_next = 8'd0;
                                p2_next = 8'd0;
                            end
                            else if (key_reg == K_WB)
                                state_next = S_WB1_RD;
                            else if (key_reg == K_WF)
                                state_next = S_WF1_RD;
                        end
                        PH_CSI:
                        begin
                            if (is_digit)
                            begin
                                p1_next = {4'b0, digit};
                                phase_next = PH_P1;
                            end
                            else
                                csi = 1'b1;
                        end
                        PH_P1:
                        begin
                            if (is_digit)
                            begin
                                p1_next = p1_sat;
                                phase_next = PH_P1;
                            end
                            else if (key_reg == K_SEMI)
                                phase_next = PH_SEMI;
                            else
                                csi = 1'b1;
                        end
                        PH_SEMI:
                        begin
                            if (is_digit)
                            begin
                                p2_next = {4'b0, digit};
                                phase_next = PH_P2;
                            end
                        end
                        PH_P2:
                        begin
                            if (is_digit)
                            begin
                                p2_next = p2_sat;
                                phase_next = PH_P2;
                            end
                            else
                                csi = 1'b1;
                        end
                        default:
                        begin
                            case (key_reg)
                                K_ESC: phase_next = PH_ESC;
                                K_HOME: cmd.cur_op = CUR_ZERO;
                                K_LEFT: if (!st.cur_zero) cmd.cur_op = CUR_DEC;
                                K_CANCEL: ev_next = EV_CANCEL;
                                K_DEL:
                                begin
                                    if (st.len_zero)
                                        ev_next = EV_EOF;
                                    else
                                        state_next = S_DEL_CHK;
                                end
                                K_END: cmd.cur_op = CUR_END;
                                K_RIGHT: if (st.cur_lt_len) cmd.cur_op = CUR_INC;
                                K_TAB: ev_next = EV_TAB;
                                K_LF, K_CR: ev_next = EV_ENTER;
                                K_KILL_EOL: cmd.len_op = LEN_CUR;
                                K_FF: ev_next = EV_CLEAR;
                                K_KILL_LINE:
                                begin
                                    cmd.cur_op = CUR_ZERO;
                                    cmd.len_op = LEN_ZERO;
                                end
                                K_KILL_WORD:
                                begin
                                    if (!st.cur_zero)
                                    begin
                                        cmd.src_op = SRC_CUR;
                                        kill_next = 1'b1;
                                        state_next = S_WB1_RD;
                                    end
                                end
                                K_BS, K_RUBOUT:
                                begin
                                    if (!st.cur_zero)
                                    begin
                                        cmd.cur_op = CUR_DEC;
                                        state_next = S_DEL_CHK;
                                    end
                                end
                                K_HELP: ev_next = EV_HELP;
                                default:
                                begin
                                    if (key_reg >= K_SPACE && key_reg < K_RUBOUT && !st.len_full)
                                    begin
                                        cmd.src_op = SRC_LEN;
                                        state_next = S_INS;
                                    end
                                end
                            endcase
                        end
                    endcase
                    if (csi)
                    begin
                        case (key_reg)
                            K_A: ev_next = EV_HIST_UP;
                            K_B: ev_next = EV_HIST_DOWN;
                            K_C:
                            begin
                                if (p2_reg == 8'd5)
                                    state_next = S_WF1_RD;
                                else if (st.cur_lt_len)
                                    cmd.cur_op = CUR_INC;
                            end
                            K_D:
                            begin
                                if (p2_reg == 8'd5)
                                    state_next = S_WB1_RD;
                                else if (!st.cur_zero)
                                    cmd.cur_op = CUR_DEC;
                            end
                            K_H: cmd.cur_op = CUR_ZERO;
                            K_F: cmd.cur_op = CUR_END;
                            K_TILDE: if (p1_reg == 8'd3) state_next = S_DEL_CHK;
                            default: ;
                        endcase
                    end
                end
            end
            S_INS:
            begin
                if (st.src_eq_cur)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_sel = WR_CUR_KEY;
                    cmd.cur_op = CUR_INC;
                    cmd.len_op = LEN_INC;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RD_SRC_M1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = WR_SRC;
                cmd.src_op = SRC_DEC;
                state_next = S_INS;
            end
            S_DEL_CHK:
            begin
                if (st.cur_lt_len)
                begin
                    cmd.dst_op = DST_CUR;
                    cmd.src_op = SRC_CUR_P1;
                    state_next = S_CP_RD;
                end
                else
                    state_next = S_FINISH;
            end
            S_CP_RD:
            begin
                if (st.src_lt_len)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RD_SRC;
                    state_next = S_CP_WR;
                end
                else
                begin
                    cmd.len_op = LEN_DST;
                    state_next = S_FINISH;
                end
            end
            S_CP_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = WR_DST;
                cmd.src_op = SRC_INC;
                cmd.dst_op = DST_INC;
                state_next = S_CP_RD;
            end
            S_WB1_RD, S_WB2_RD:
            begin
                if (st.cur_zero)
                begin
                    cmd.dst_op = DST_CUR;
                    state_next = kill_reg ? S_CP_RD : S_FINISH;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RD_CUR_M1;
                    state_next = (state_reg == S_WB1_RD) ? S_WB1_CK : S_WB2_CK;
                end
            end
            S_WB1_CK:
            begin
                if (st.rd_space)
                begin
                    cmd.cur_op = CUR_DEC;
                    state_next = S_WB1_RD;
                end
                else
                    state_next = S_WB2_RD;
            end
            S_WB2_CK:
            begin
                if (!st.rd_space)
                begin
                    cmd.cur_op = CUR_DEC;
                    state_next = S_WB2_RD;
                end
                else
                begin
                    cmd.dst_op = DST_CUR;
                    state_next = kill_reg ? S_CP_RD : S_FINISH;
                end
            end
            S_WF1_RD, S_WF2_RD:
            begin
                if (!st.cur_lt_len)
                    state_next = S_FINISH;
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = (state_reg == S_WF1_RD) ? S_WF1_CK : S_WF2_CK;
                end
            end
            S_WF1_CK:
            begin
                if (!st.rd_space)
                begin
                    cmd.cur_op = CUR_INC;
                    state_next = S_WF1_RD;
                end
                else
                    state_next = S_WF2_RD;
            end
            S_WF2_CK:
            begin
                if (st.rd_space)
                begin
                    cmd.cur_op = CUR_INC;
                    state_next = S_WF2_RD;
                end
                else
                    state_next = S_FINISH;
            end
            S_READ_WAIT:
            begin
                rc_next = st.rdata;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ev_next = ev_reg;
                    out_cur_next = st.cur7;
                    out_len_next = st.len7;
                    out_rc_next = rc_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_NONE;
            p1_reg <= 8'd0;
            p2_reg <= 8'd0;
            kill_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            kill_reg <= kill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        ev_reg <= ev_next;
        rc_reg <= rc_next;
        out_ev_reg <= out_ev_next;
        out_cur_reg <= out_cur_next;
        out_len_reg <= out_len_next;
        out_rc_reg <= out_rc_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign event_res = out_ev_reg;
    assign cursor_out = out_cur_reg;
    assign length_out = out_len_reg;
    assign read_char = out_rc_reg;
endmodule
`default_nettype wire

// File: hdl/terminal_line_editor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Line editor for terminal key bytes with an ESC/CSI parser. One request is
// taken at a time and gives one result. Insert and delete shift the line one
// character at a time, word moves scan one character at a time, and kill-word
// also moves the characters after the cursor, all through the line memory
// walked by the sequencer. A result may wait in the output register while the
// next request is taken.
module terminal_line_editor_top
    import tle_pkg::*;
#(
    parameter int LINE_SIZE = 128
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic [1:0] func,
    input wire logic [7:0] key_byte,
    input wire logic [6:0] read_index,
    output logic out_valid,
    input wire logic out_stall,
    output logic [3:0] event_res,
    output logic [6:0] cursor_out,
    output logic [6:0] length_out,
    output logic [7:0] read_char
);
    `include "terminal_line_editor_top_assert.svh"

    dp_cmd_t cmd;
    dp_status_t st;

    tle_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .key_byte(key_byte),
        .read_index(read_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .cursor_out(cursor_out),
        .length_out(length_out),
        .read_char(read_char),
        .cmd(cmd),
        .st(st)
    );

    tle_datapath #(
        .LINE_SIZE(LINE_SIZE)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .st(st)
    );

    `TLE_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "not busy after request")
    `TLE_ASSERT_NOW(a_event_range, out_valid, event_res <= EV_HELP, "event code out of range")
    `TLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
endmodule
`default_nettype wire
